@@ rtl/pcl_pkg.sv @@
// ----------------------------------------------------------------------------
// pcl_pkg
// shared constants, codes and types of the positional character list
// ----------------------------------------------------------------------------
`default_nettype none

package pcl_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int GROUP  = 8;
	localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

	localparam int OP_W   = 2;
	localparam int POS_W  = 7;
	localparam int CHAR_W = 8;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_SUM,
		FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic              ins;
		logic              del;
		logic [IDX_W-1:0]  pidx;
		logic [CHAR_W-1:0] ch;
	} cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/pcl_req_if.sv @@
// ----------------------------------------------------------------------------
// pcl_req_if
// request channel: operation, position and character to insert
// ----------------------------------------------------------------------------
`default_nettype none

interface pcl_req_if;
	logic                       valid;
	logic                       ready;
	logic [pcl_pkg::OP_W-1:0]   operation;
	logic [pcl_pkg::POS_W-1:0]  position;
	logic [pcl_pkg::CHAR_W-1:0] new_char;

	modport source (output valid, output operation, output position, output new_char,
		input ready);
	modport sink (input valid, input operation, input position, input new_char,
		output ready);
endinterface

`default_nettype wire

@@ rtl/pcl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pcl_rsp_if
// response channel: character read or removed, status and list length
// ----------------------------------------------------------------------------
`default_nettype none

interface pcl_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [pcl_pkg::CHAR_W-1:0] read_char;
	logic [pcl_pkg::STAT_W-1:0] status;
	logic [pcl_pkg::LEN_W-1:0]  length_now;

	modport source (output valid, output read_char, output status, output length_now,
		input ready);
	modport sink (input valid, input read_char, input status, input length_now,
		output ready);
endinterface

`default_nettype wire

@@ rtl/pcl_cell.sv @@
// ----------------------------------------------------------------------------
// pcl_cell
// one list slot: holds, loads, or takes its left or right neighbor's character
// ----------------------------------------------------------------------------
`default_nettype none

module pcl_cell (
	input  wire logic                       clk,
	input  wire logic [pcl_pkg::IDX_W-1:0]  idx,
	input  wire pcl_pkg::cell_cmd_t         cmd,
	input  wire logic [pcl_pkg::CHAR_W-1:0] left,
	input  wire logic [pcl_pkg::CHAR_W-1:0] right,
	output logic      [pcl_pkg::CHAR_W-1:0] val,
	output logic      [pcl_pkg::CHAR_W-1:0] tap
);

	logic [pcl_pkg::CHAR_W-1:0] val_q;
	logic [pcl_pkg::CHAR_W-1:0] nxt;
	logic                       hit;
	logic                       above;

	always_comb begin
		hit   = (idx == cmd.pidx);
		above = (idx > cmd.pidx);
		nxt   = val_q;
		if (cmd.ins) begin
			if (above) begin
				nxt = left;
			end else if (hit) begin
				nxt = cmd.ch;
			end
		end else if (cmd.del && (above || hit)) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= nxt;
	end

	assign val = val_q;
	assign tap = hit ? val_q : '0;

endmodule

`default_nettype wire

@@ rtl/positional_char_list_core.sv @@
// ----------------------------------------------------------------------------
// positional_char_list_core
// ordered character list in a row of shifting cells with an element count
//
//   channel  dir  beat payload
//   req      in   operation, position, new_char
//   rsp      out  read_char, status, length_now
//
// each beat steps through accept, cell update, read tree and result states
// the cell row updates all cells together; the read goes through a registered
// or tree of groups of eight cells
// reset empties the list; cell contents are not cleared
// a stalled rsp holds the result and keeps req not ready
// ----------------------------------------------------------------------------
`default_nettype none

module positional_char_list_core (
	input  wire logic clk,
	input  wire logic arst_n,
	pcl_req_if.sink   req,
	pcl_rsp_if.source rsp
);

	pcl_pkg::fsm_t                state_q;
	pcl_pkg::fsm_t                state_d;
	logic [pcl_pkg::OP_W-1:0]     op_q;
	logic [pcl_pkg::POS_W-1:0]    pos_q;
	logic [pcl_pkg::CHAR_W-1:0]   ch_q;
	logic [pcl_pkg::CNT_W-1:0]    count_q;
	logic [pcl_pkg::STAT_W-1:0]   status_q;
	logic                         rd_q;
	logic [pcl_pkg::CHAR_W-1:0]   char_q;
	logic [pcl_pkg::CHAR_W-1:0]   grp_s1 [pcl_pkg::NGROUP];

	logic [pcl_pkg::CMP_W-1:0]    pos_w;
	logic [pcl_pkg::CMP_W-1:0]    cnt_w;
	logic [pcl_pkg::CMP_W-1:0]    pm1;
	logic                         in_rng;
	logic                         in_rng_ins;
	logic                         full;
	logic                         do_ins;
	logic                         do_del;
	logic                         do_rd;
	logic [pcl_pkg::STAT_W-1:0]   stat_d;
	logic [pcl_pkg::CHAR_W-1:0]   sum;
	pcl_pkg::cell_cmd_t           cmd;

	logic [pcl_pkg::CHAR_W-1:0]   vals [pcl_pkg::DEPTH];
	logic [pcl_pkg::CHAR_W-1:0]   taps [pcl_pkg::DEPTH];
	logic [pcl_pkg::CHAR_W-1:0]   grp_d [pcl_pkg::NGROUP];

	// request decode against the current count
	always_comb begin
		pos_w      = pcl_pkg::CMP_W'(pos_q);
		cnt_w      = pcl_pkg::CMP_W'(count_q);
		pm1        = pos_w - 1'b1;
		in_rng     = (pos_w != '0) && (pos_w <= cnt_w);
		in_rng_ins = (pos_w != '0) && (pos_w <= cnt_w + 1'b1);
		full       = (cnt_w >= pcl_pkg::CMP_W'(pcl_pkg::DEPTH));
		do_ins     = 1'b0;
		do_del     = 1'b0;
		do_rd      = 1'b0;
		stat_d     = pcl_pkg::ST_RANGE;
		unique case (op_q)
			pcl_pkg::OP_READ: begin
				if (in_rng) begin
					do_rd  = 1'b1;
					stat_d = pcl_pkg::ST_DONE;
				end
			end
			pcl_pkg::OP_INSERT: begin
				if (full) begin
					stat_d = pcl_pkg::ST_FULL;
				end else if (in_rng_ins) begin
					do_ins = 1'b1;
					stat_d = pcl_pkg::ST_DONE;
				end
			end
			pcl_pkg::OP_DELETE: begin
				if (in_rng) begin
					do_del = 1'b1;
					do_rd  = 1'b1;
					stat_d = pcl_pkg::ST_DONE;
				end
			end
			default: begin
				stat_d = pcl_pkg::ST_RANGE;
			end
		endcase
	end

	always_comb begin
		cmd.ins  = do_ins && (state_q == pcl_pkg::FSM_EXEC);
		cmd.del  = do_del && (state_q == pcl_pkg::FSM_EXEC);
		cmd.pidx = pm1[pcl_pkg::IDX_W-1:0];
		cmd.ch   = ch_q;
	end

	for (genvar k = 0; k < pcl_pkg::DEPTH; k++) begin : g_cell
		logic [pcl_pkg::CHAR_W-1:0] lft;
		logic [pcl_pkg::CHAR_W-1:0] rgt;

		if (k == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid_l
			assign lft = vals[k-1];
		end
		if (k == pcl_pkg::DEPTH - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_mid_r
			assign rgt = vals[k+1];
		end

		pcl_cell u_cell (
			.clk   (clk),
			.idx   (pcl_pkg::IDX_W'(k)),
			.cmd   (cmd),
			.left  (lft),
			.right (rgt),
			.val   (vals[k]),
			.tap   (taps[k])
		);
	end

	// first level of the read tree
	always_comb begin
		for (int g = 0; g < pcl_pkg::NGROUP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < pcl_pkg::GROUP; j++) begin
				if (g * pcl_pkg::GROUP + j < pcl_pkg::DEPTH) begin
					grp_d[g] = grp_d[g] | taps[g * pcl_pkg::GROUP + j];
				end
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int g = 0; g < pcl_pkg::NGROUP; g++) begin
			sum = sum | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pcl_pkg::FSM_EXEC) begin
			grp_s1 <= grp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.operation;
			pos_q <= req.position;
			ch_q  <= req.new_char;
		end
		if (state_q == pcl_pkg::FSM_EXEC) begin
			status_q <= stat_d;
			rd_q     <= do_rd;
		end
		if (state_q == pcl_pkg::FSM_SUM) begin
			char_q <= rd_q ? sum : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcl_pkg::FSM_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.ins) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.del) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		unique case (state_q)
			pcl_pkg::FSM_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = pcl_pkg::FSM_EXEC;
				end
			end
			pcl_pkg::FSM_EXEC: begin
				state_d = pcl_pkg::FSM_SUM;
			end
			pcl_pkg::FSM_SUM: begin
				state_d = pcl_pkg::FSM_OUT;
			end
			pcl_pkg::FSM_OUT: begin
				rsp.valid = 1'b1;
				if (rsp.ready) begin
					state_d = pcl_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = pcl_pkg::FSM_IDLE;
			end
		endcase
	end

	assign rsp.read_char  = char_q;
	assign rsp.status     = status_q;
	assign rsp.length_now = pcl_pkg::LEN_W'(count_q);

endmodule

`default_nettype wire

@@ verif/positional_char_list_core_tb.sv @@
// ----------------------------------------------------------------------------
// positional_char_list_core_tb
// self-checking bench for the positional character list: a directed opening
// on an empty and a short list, then random read, insert and delete requests
// that fill the list up to its depth and drain it again, with random idling
// on both channels and one long response stall; every response is checked
// against a list kept in the bench
// ----------------------------------------------------------------------------
`default_nettype none

module positional_char_list_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [pcl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int N_RANDOM = 1500;
	localparam int CALM_LO = 700;
	localparam int CALM_HI = 900;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [pcl_pkg::OP_W-1:0]   op;
		logic [pcl_pkg::POS_W-1:0]  pos;
		logic [pcl_pkg::CHAR_W-1:0] ch;
	} list_req_t;

	typedef struct packed {
		logic [pcl_pkg::CHAR_W-1:0] ch;
		logic [pcl_pkg::STAT_W-1:0] status;
		logic [pcl_pkg::LEN_W-1:0]  len;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pcl_req_if req_ch ();
	pcl_rsp_if rsp_ch ();

	positional_char_list_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_req_t pending[$];
	list_rsp_t list_answers[$];
	logic [pcl_pkg::CHAR_W-1:0] list_cells [pcl_pkg::DEPTH];
	int list_len = 0;
	int sent = 0;
	int rsp_seen = 0;
	int fails = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic list_rsp_t edit_list(list_req_t r);
		list_rsp_t a;
		int p;
		a = '0;
		a.status = pcl_pkg::ST_DONE;
		p = int'(r.pos);
		case (r.op)
		pcl_pkg::OP_READ: begin
			if (p >= 1 && p <= list_len)
				a.ch = list_cells[p-1];
			else
				a.status = pcl_pkg::ST_RANGE;
		end
		pcl_pkg::OP_INSERT: begin
			if (list_len >= pcl_pkg::DEPTH) begin
				a.status = pcl_pkg::ST_FULL;
			end else if (p >= 1 && p <= list_len + 1) begin
				for (int k = list_len; k > p - 1; k--)
					list_cells[k] = list_cells[k-1];
				list_cells[p-1] = r.ch;
				list_len++;
			end else begin
				a.status = pcl_pkg::ST_RANGE;
			end
		end
		pcl_pkg::OP_DELETE: begin
			if (p >= 1 && p <= list_len) begin
				a.ch = list_cells[p-1];
				for (int k = p - 1; k + 1 < list_len; k++)
					list_cells[k] = list_cells[k+1];
				list_len--;
			end else begin
				a.status = pcl_pkg::ST_RANGE;
			end
		end
		default: begin
			a.status = pcl_pkg::ST_RANGE;
		end
		endcase
		a.len = pcl_pkg::LEN_W'(list_len);
		return a;
	endfunction

	// length after a request, used only to steer the random mix
	function automatic int len_after(list_req_t r, int len);
		if (r.op == pcl_pkg::OP_INSERT && len < pcl_pkg::DEPTH && r.pos >= 1
				&& r.pos <= len + 1)
			return len + 1;
		if (r.op == pcl_pkg::OP_DELETE && r.pos >= 1 && r.pos <= len)
			return len - 1;
		return len;
	endfunction

	function automatic int pick_pos(int hi);
		int roll;
		roll = int'($urandom_range(0, 5));
		if (hi < 1)
			hi = 1;
		if (roll == 0)
			return 1;
		if (roll == 1)
			return hi;
		return int'($urandom_range(1, hi));
	endfunction

	function automatic void log_fail(string msg);
		fails++;
		if (fails <= 10)
			$display("%s", msg);
	endfunction

	function automatic void add_req(logic [pcl_pkg::OP_W-1:0] op, int pos,
			logic [pcl_pkg::CHAR_W-1:0] ch);
		list_req_t r;
		r.op = op;
		r.pos = pcl_pkg::POS_W'(pos);
		r.ch = ch;
		pending.push_back(r);
	endfunction

	initial begin
		list_req_t r;
		int gen_len;
		bit filling;
		int roll;
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.position = '0;
		req_ch.new_char = '0;
		rsp_ch.ready = 1'b0;

		// empty list, bad positions, a short list built at both ends, then reads and edits on it
		add_req(pcl_pkg::OP_READ, 1, 8'h00);
		add_req(pcl_pkg::OP_DELETE, 1, 8'h00);
		add_req(pcl_pkg::OP_INSERT, 0, 8'h11);
		add_req(pcl_pkg::OP_INSERT, 2, 8'h22);
		add_req(pcl_pkg::OP_INSERT, 1, 8'h00);
		add_req(pcl_pkg::OP_INSERT, 2, 8'hFF);
		add_req(pcl_pkg::OP_INSERT, 1, 8'hA5);
		add_req(pcl_pkg::OP_INSERT, 2, 8'h5A);
		add_req(pcl_pkg::OP_READ, 1, 8'hFF);
		add_req(pcl_pkg::OP_READ, 2, 8'h00);
		add_req(pcl_pkg::OP_READ, 3, 8'h00);
		add_req(pcl_pkg::OP_READ, 4, 8'h00);
		add_req(pcl_pkg::OP_READ, 5, 8'h00);
		add_req(pcl_pkg::OP_READ, 0, 8'h00);
		add_req(pcl_pkg::OP_READ, 127, 8'h00);
		add_req(OP_UNUSED, 1, 8'hFF);
		add_req(pcl_pkg::OP_INSERT, 6, 8'h33);
		add_req(pcl_pkg::OP_INSERT, 127, 8'h44);
		add_req(pcl_pkg::OP_DELETE, 5, 8'h00);
		add_req(pcl_pkg::OP_DELETE, 0, 8'h00);
		add_req(pcl_pkg::OP_DELETE, 2, 8'h00);
		add_req(pcl_pkg::OP_DELETE, 3, 8'h00);
		add_req(pcl_pkg::OP_DELETE, 1, 8'h00);
		add_req(pcl_pkg::OP_READ, 64, 8'h00);
		add_req(pcl_pkg::OP_READ, 1, 8'h00);

		gen_len = 0;
		foreach (pending[i])
			gen_len = len_after(pending[i], gen_len);
		filling = 1'b1;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (gen_len >= pcl_pkg::DEPTH)
				filling = 1'b0;
			else if (gen_len == 0)
				filling = 1'b1;
			r.ch = pcl_pkg::CHAR_W'($urandom);
			roll = int'($urandom_range(0, 99));
			if (roll < 8) begin
				r.op = pcl_pkg::OP_W'($urandom);
				r.pos = pcl_pkg::POS_W'($urandom);
			end else begin
				roll = int'($urandom_range(0, 99));
				if (roll < 20)
					r.op = pcl_pkg::OP_READ;
				else if (roll < 80)
					r.op = filling ? pcl_pkg::OP_INSERT : pcl_pkg::OP_DELETE;
				else
					r.op = filling ? pcl_pkg::OP_DELETE : pcl_pkg::OP_INSERT;
				r.pos = pcl_pkg::POS_W'(pick_pos(r.op == pcl_pkg::OP_INSERT ?
					gen_len + 1 : gen_len));
			end
			pending.push_back(r);
			gen_len = len_after(r, gen_len);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || list_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("** positional_char_list_core: PASSED **");
		else
			$display("** positional_char_list_core: FAILED **");
		$finish;
	end

	initial begin
		#(12 * 300000);
		$display("** positional_char_list_core: FAILED **");
		$finish;
	end

	// request driver
	always @(posedge clk) begin
		bit calm;
		bit gap;
		bit took;
		calm = (sent >= CALM_LO && sent < CALM_HI);
		gap = !calm && ($urandom_range(0, 99) < 24);
		took = req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (took) begin
				list_answers.push_back(edit_list(pending.pop_front()));
				sent++;
			end
			if (!req_ch.valid || took) begin
				if (pending.size() != 0 && !gap) begin
					req_ch.valid <= 1'b1;
					req_ch.operation <= pending[0].op;
					req_ch.position <= pending[0].pos;
					req_ch.new_char <= pending[0].ch;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long response stall, once
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && rsp_seen >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// response monitor
	always @(posedge clk) begin
		list_rsp_t want;
		bit calm;
		calm = (rsp_seen >= CALM_LO && rsp_seen < CALM_HI);
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_seen++;
				if (list_answers.size() == 0) begin
					log_fail($sformatf("unexpected beat: ch %02h status %0d len %0d",
						rsp_ch.read_char, rsp_ch.status, rsp_ch.length_now));
				end else begin
					want = list_answers.pop_front();
					if (rsp_ch.read_char !== want.ch || rsp_ch.status !== want.status
							|| rsp_ch.length_now !== want.len)
						log_fail($sformatf({"beat %0d: expected ch %02h status %0d ",
							"len %0d, got ch %02h status %0d len %0d"},
							rsp_seen, want.ch, want.status, want.len,
							rsp_ch.read_char, rsp_ch.status, rsp_ch.length_now));
				end
			end
			if (hold_left != 0)
				rsp_ch.ready <= 1'b0;
			else if (calm)
				rsp_ch.ready <= 1'b1;
			else
				rsp_ch.ready <= ($urandom_range(0, 99) >= 24);
		end
	end

endmodule

`default_nettype wire
